/* sv/swmt_pkg.sv */
`default_nettype none

package swmt_pkg;

   // Defaults for the top-level parameters
   localparam int WINDOW_MAX_DEF   = 256;
   localparam int SYMBOL_COUNT_DEF = 32;

   // Fixed port widths
   localparam int CFG_W     = 9;
   localparam int SYM_W     = 5;
   localparam int CSR_IDX_W = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REQUIRED_COUNT = 1'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] WINDOW_SIZE_RST    = 9'd16;
   localparam logic [CFG_W-1:0] REQUIRED_COUNT_RST = 9'd8;

endpackage

`default_nettype wire

/* sv/swmt_ram.sv */
`default_nettype none

module swmt_ram #(
   parameter int DataW = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [DataW-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [DataW-1:0]         rd_data
);

   logic [DataW-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/swmt_cell.sv */
`default_nettype none

// One symbol's counter and latest ring slot; folds its state into the
// scan record passing by and hands the record to the next cell.
module swmt_cell #(
   parameter int  SymbolCount = 32,
   parameter int  WindowMax   = 256,
   parameter int  CellIndex   = 0,
   parameter type rec_type    = logic,
   parameter type ctx_type    = logic,
   parameter type upd_type    = logic
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire upd_type upd,
   input  wire ctx_type ctx,
   input  wire rec_type rec_i,
   output rec_type      rec_o
);
   import swmt_pkg::*;

   localparam int SymW   = $clog2(SymbolCount);
   localparam int PtrW   = $clog2(WindowMax);
   localparam int CountW = $clog2(WindowMax + 1);
   localparam int CmpW   = (CountW > CFG_W) ? CountW : CFG_W;
   localparam logic [SymW-1:0] MyIdx = SymW'(CellIndex);

   logic [CountW-1:0] count_ff, count_in;
   logic [PtrW-1:0]   pos_ff, pos_in;
   rec_type           rec_ff, rec_in;
   logic              dec, inc;
   logic [PtrW:0]     age_diff;
   logic [PtrW-1:0]   age;

   // Window update: at most one leave and one enter per transaction
   always_comb begin
      dec      = upd.evict && (upd.old_sym == MyIdx) && (count_ff != '0);
      inc      = (upd.new_sym == MyIdx);
      count_in = count_ff;
      pos_in   = pos_ff;
      if (upd.en) begin
         count_in = count_ff - CountW'(dec) + CountW'(inc);
         if (inc) begin
            pos_in = upd.wp;
         end
      end
   end

   // Age since this symbol's latest write, modulo ring depth
   always_comb begin
      age_diff = {1'b0, ctx.newest} - {1'b0, pos_ff};
      if (age_diff[PtrW]) begin
         age_diff = age_diff + (PtrW+1)'(WindowMax);
      end
      age = age_diff[PtrW-1:0];
   end

   always_comb begin
      rec_in = rec_i;
      if (ctx.full && !rec_i.found &&
          (CmpW'(count_ff) >= CmpW'(ctx.required))) begin
         rec_in.found    = 1'b1;
         rec_in.stop_sym = MyIdx;
      end
      if ((count_ff != '0) &&
          ((count_ff > rec_i.best_count) ||
           ((count_ff == rec_i.best_count) && (age < rec_i.best_age)))) begin
         rec_in.best_count = count_ff;
         rec_in.best_sym   = MyIdx;
         rec_in.best_age   = age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         rec_ff.valid <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         if (rec_i.valid) begin
            rec_ff <= rec_in;
         end else begin
            rec_ff.valid <= 1'b0;
         end
      end
   end

   assign rec_o = rec_ff;

endmodule

`default_nettype wire

/* sv/sliding_window_mode_tracker.sv */
`default_nettype none

// Result path: the ring read and count update, the scan record launch register, one
//   register per symbol cell, then the response register.
// Requests: a new transaction is taken only once the scan record of the last one has
//   walked the cell chain and its result is loaded; a result still waiting when the next
//   scan ends holds the sequencer, and with it the request side, until it is taken.
// Reset: counts, last positions, write pointer and fill level cleared,
//   window_size = 16, required_count = 8; ring contents are not cleared.
module sliding_window_mode_tracker #(
   parameter int WindowMax   = swmt_pkg::WINDOW_MAX_DEF,
   parameter int SymbolCount = swmt_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [swmt_pkg::SYM_W-1:0]     req_symbol,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_window_full,
   output logic                                rsp_stop_found,
   output logic      [swmt_pkg::SYM_W-1:0]     rsp_stop_symbol,
   output logic      [swmt_pkg::SYM_W-1:0]     rsp_plurality_symbol,
   // register writes
   input  wire logic                           csr_write_enable,
   input  wire logic [swmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [swmt_pkg::CFG_W-1:0]     csr_write_data
);
   import swmt_pkg::*;

   localparam int SymW   = $clog2(SymbolCount);
   localparam int PtrW   = $clog2(WindowMax);
   localparam int CountW = $clog2(WindowMax + 1);   // also the fill level width
   localparam int WinW   = (CountW > CFG_W) ? CountW : CFG_W;
   localparam int OutW   = (SymW > SYM_W) ? SymW : SYM_W;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a request
   localparam logic [1:0] ST_UPD  = 2'd1;   // ring data back, update counts
   localparam logic [1:0] ST_SCAN = 2'd2;   // record walking the cells
   localparam logic [1:0] ST_OUT  = 2'd3;   // result held for a busy response

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [SymW-1:0]   stop_sym;
      logic [CountW-1:0] best_count;
      logic [SymW-1:0]   best_sym;
      logic [PtrW-1:0]   best_age;
   } scan_rec_type;

   typedef struct packed {
      logic             full;
      logic [CFG_W-1:0] required;
      logic [PtrW-1:0]  newest;
   } scan_ctx_type;

   typedef struct packed {
      logic            en;
      logic            evict;
      logic [SymW-1:0] old_sym;
      logic [SymW-1:0] new_sym;
      logic [PtrW-1:0] wp;
   } win_upd_type;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  win_size_ff, req_count_ff;
   logic [PtrW-1:0]   wp_ff;
   logic [CountW-1:0] fill_ff;
   logic [SymW-1:0]   sym_ff;
   logic              evict_ff;
   scan_ctx_type      ctx_ff;
   scan_rec_type      head_ff;
   scan_rec_type      chain [SymbolCount+1];

   logic              rsp_valid_ff;
   logic              rsp_full_ff, rsp_found_ff;
   logic [SYM_W-1:0]  rsp_stop_ff, rsp_plur_ff;

   logic              req_fire, rsp_free, rsp_load;
   logic [WinW-1:0]   win_ext;
   logic [CountW-1:0] win;
   logic              evict;
   logic [CountW:0]   oldest_diff;
   logic [PtrW-1:0]   oldest_idx;
   logic [CountW-1:0] fill_next;
   logic [PtrW-1:0]   wp_next;
   logic [SymW-1:0]   ram_rd_data;
   win_upd_type       upd;
   logic [SymW-1:0]   sym_mod_tab [2**SYM_W];
   logic [OutW-1:0]   stop_wide, plur_wide;

   // Incoming codes reduced modulo the symbol count: constant table
   for (genvar g = 0; g < 2**SYM_W; g++) begin : g_mod_tab
      assign sym_mod_tab[g] = SymW'(g % SymbolCount);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Effective window: zero acts as one, clamp to ring depth
   always_comb begin
      win_ext = WinW'(win_size_ff);
      if (win_size_ff == '0) begin
         win_ext = WinW'(1);
      end else if (win_ext > WinW'(WindowMax)) begin
         win_ext = WinW'(WindowMax);
      end
      win = CountW'(win_ext);
   end

   // Pushing would overflow the window: the oldest symbol leaves first
   assign evict = (fill_ff >= win);

   // Oldest slot = write pointer - fill level, modulo ring depth
   always_comb begin
      oldest_diff = (CountW+1)'(wp_ff) - (CountW+1)'(fill_ff);
      if (oldest_diff[CountW]) begin
         oldest_diff = oldest_diff + (CountW+1)'(WindowMax);
      end
      oldest_idx = oldest_diff[PtrW-1:0];
   end

   assign fill_next = evict_ff ? fill_ff : CountW'(fill_ff + 1'b1);
   assign wp_next   = (wp_ff == PtrW'(WindowMax - 1)) ? '0 : PtrW'(wp_ff + 1'b1);

   // Ring read issued with the transaction, write in the update cycle
   swmt_ram #(
      .DataW (SymW),
      .Depth (WindowMax)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPD),
      .wr_addr (wp_ff),
      .wr_data (sym_ff),
      .rd_en   (req_fire),
      .rd_addr (oldest_idx),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      upd.en      = (state_ff == ST_UPD);
      upd.evict   = evict_ff;
      upd.old_sym = ram_rd_data;
      upd.new_sym = sym_ff;
      upd.wp      = wp_ff;
   end

   // Cell chain: one cell per symbol, record advances one cell per cycle
   assign chain[0] = head_ff;

   for (genvar k = 0; k < SymbolCount; k++) begin : g_cell
      swmt_cell #(
         .SymbolCount (SymbolCount),
         .WindowMax   (WindowMax),
         .CellIndex   (k),
         .rec_type    (scan_rec_type),
         .ctx_type    (scan_ctx_type),
         .upd_type    (win_upd_type)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .upd   (upd),
         .ctx   (ctx_ff),
         .rec_i (chain[k]),
         .rec_o (chain[k+1])
      );
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (chain[SymbolCount].valid) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= WINDOW_SIZE_RST;
         req_count_ff <= REQUIRED_COUNT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_WINDOW_SIZE:    win_size_ff  <= csr_write_data;
            REG_REQUIRED_COUNT: req_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Window pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (state_ff == ST_UPD) begin
         wp_ff   <= wp_next;
         fill_ff <= fill_next;
      end
   end

   // Per-transaction payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sym_ff   <= sym_mod_tab[req_symbol];
         evict_ff <= evict;
      end
      if (state_ff == ST_UPD) begin
         ctx_ff.full     <= (fill_next >= win);
         ctx_ff.required <= req_count_ff;
         ctx_ff.newest   <= wp_ff;
      end
   end

   // Scan record launch: nothing found yet, plurality defaults to new symbol
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (state_ff == ST_UPD) begin
         head_ff.valid      <= 1'b1;
         head_ff.found      <= 1'b0;
         head_ff.stop_sym   <= '0;
         head_ff.best_count <= '0;
         head_ff.best_sym   <= sym_ff;
         head_ff.best_age   <= '0;
      end else begin
         head_ff.valid <= 1'b0;
      end
   end

   // Response register
   assign stop_wide = OutW'(chain[SymbolCount].stop_sym);
   assign plur_wide = OutW'(chain[SymbolCount].best_sym);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_full_ff  <= ctx_ff.full;
         rsp_found_ff <= chain[SymbolCount].found;
         rsp_stop_ff  <= stop_wide[SYM_W-1:0];
         rsp_plur_ff  <= plur_wide[SYM_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_full      = rsp_full_ff;
   assign rsp_stop_found       = rsp_found_ff;
   assign rsp_stop_symbol      = rsp_stop_ff;
   assign rsp_plurality_symbol = rsp_plur_ff;

endmodule

`default_nettype wire
